// File: rtl/svm_pkg.sv
// ----------------------------------------------------------------------------
// svm_pkg
// Shared widths, codes and pitch arithmetic for the sample playback mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package svm_pkg;

  localparam int VOICE_COUNT = 16;
  localparam int VOICE_W     = $clog2(VOICE_COUNT);
  localparam int FRAC_W      = 16;
  localparam int ADDR_W      = 16;
  localparam int LEN_W       = ADDR_W + 1;
  localparam int INT_W       = 18;
  localparam int POS_W       = INT_W + FRAC_W;
  localparam int RATE_W      = 22;
  localparam int SAMPLE_W    = 16;
  localparam int NOTE_W      = 7;
  localparam int VEL_W       = 7;
  localparam int MIX_W       = 22;

  localparam logic [LEN_W-1:0] SAMPLE_DEPTH = LEN_W'(65536);

  // floor(2^30 / 127): a reciprocal one short at most, fixed by one correction.
  localparam logic [24:0] RECIP_127 = 25'd8454660;
  localparam int RECIP_SHIFT = 30;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_NOTE = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic CFG_LENGTH = 1'b0;
  localparam logic CFG_LOOP   = 1'b1;

  // 2^(k/12) in Q1.24.
  function automatic logic [24:0] semitone(input logic [3:0] k);
    logic [24:0] t;
    case (k)
      4'd0:    t = 25'd16777216;
      4'd1:    t = 25'd17774841;
      4'd2:    t = 25'd18831788;
      4'd3:    t = 25'd19951585;
      4'd4:    t = 25'd21137968;
      4'd5:    t = 25'd22394897;
      4'd6:    t = 25'd23726566;
      4'd7:    t = 25'd25137421;
      4'd8:    t = 25'd26632170;
      4'd9:    t = 25'd28215802;
      4'd10:   t = 25'd29893600;
      4'd11:   t = 25'd31671166;
      default: t = 25'd0;
    endcase
    return t;
  endfunction

  // Playback rate for a note in Q6.16, rounding half up on the octave shift.
  function automatic logic [RATE_W-1:0] pitch_rate(input logic [NOTE_W-1:0] note);
    logic [12:0] prod;
    logic [3:0]  oct;
    logic [6:0]  semi;
    logic [3:0]  sh;
    logic [24:0] t;
    logic [24:0] sum;
    // note * 43 / 512 equals note / 12 for every 7-bit note.
    prod = 13'(note) * 13'd43;
    oct  = prod[12:9];
    semi = note - (7'({oct, 3'b000}) + 7'({oct, 2'b00}));
    sh   = 4'd13 - oct;
    t    = semitone(semi[3:0]);
    sum  = t + (25'd1 << (sh - 4'd1));
    return RATE_W'(sum >> sh);
  endfunction

endpackage

`default_nettype wire

// File: rtl/sample_playback_voice_mixer.sv
// ----------------------------------------------------------------------------
// sample_playback_voice_mixer
// Sixteen-voice sample player: one shared multiplier interpolates, scales and
// divides each voice in turn under a small sequencer, then the mix saturates.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  s_*       in         op, sample_address, sample_value, note_number, velocity
//  m_*       out        mix_sample, one beat per tick item
//  cfg_*     in         register index and data, always ready
//
//  A load or note item passes through the execute state. A tick checks each
//  voice in turn: a silent voice is skipped, a sounding one runs the read,
//  multiply and correction states, after the remainder unit when it wraps, and
//  the mix leaves through the output state. The input is not ready while an
//  item is in work; a finished tick waits for the output register to free.
//  Reset clears control state only; sample memory needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_playback_voice_mixer
  import svm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [1:0] op, [17:2] sample_address, [33:18] sample_value,
  // [40:34] note_number, [47:41] velocity
  input  wire logic [47:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [15:0] mix_sample
  output logic      [15:0] m_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [16:0] cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EXEC = 4'd1;
  localparam logic [3:0] S_VCHK = 4'd2;
  localparam logic [3:0] S_VMOD = 4'd3;
  localparam logic [3:0] S_RD0  = 4'd4;
  localparam logic [3:0] S_RD1  = 4'd5;
  localparam logic [3:0] S_MUL1 = 4'd6;
  localparam logic [3:0] S_MUL2 = 4'd7;
  localparam logic [3:0] S_MUL3 = 4'd8;
  localparam logic [3:0] S_CORR = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0] state;

  logic [LEN_W-1:0] sample_length;
  logic             loop_enable;
  logic [LEN_W-1:0] len_eff;

  logic [1:0]          op_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [SAMPLE_W-1:0] value_q;
  logic [NOTE_W-1:0]   note_q;
  logic [VEL_W-1:0]    vel_q;

  logic                voice_active   [VOICE_COUNT];
  logic [NOTE_W-1:0]   voice_note     [VOICE_COUNT];
  logic [POS_W-1:0]    voice_position [VOICE_COUNT];
  logic [RATE_W-1:0]   voice_rate     [VOICE_COUNT];
  logic [VEL_W-1:0]    voice_velocity [VOICE_COUNT];

  logic [VOICE_W-1:0]  vcnt;
  logic [VOICE_W-1:0]  slot;
  logic [MIX_W-1:0]    mix;
  logic [SAMPLE_W-1:0] s0;
  logic                neg_q;
  logic [22:0]         mag_q;

  logic [POS_W-1:0]    cur_pos;
  logic [ADDR_W-1:0]   i0;
  logic [ADDR_W:0]     i0p1;
  logic [ADDR_W-1:0]   i1;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_addr;
  logic [SAMPLE_W-1:0] mem_rdata;

  logic                mod_start;
  logic                mod_done;
  logic [LEN_W-1:0]    mod_rem;

  logic signed [23:0]  mul_a;
  logic signed [24:0]  mul_b;
  logic signed [48:0]  mul_p;

  logic [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]   interp;
  logic [23:0]         scaled;
  logic [22:0]         mag;
  logic [15:0]         q_est;
  logic [23:0]         rem127;
  logic [15:0]         q_fix;
  logic [MIX_W-1:0]    q_ext;
  logic [15:0]         sat;
  logic                last_voice;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign len_eff   = (sample_length > SAMPLE_DEPTH) ? SAMPLE_DEPTH : sample_length;

  assign cur_pos    = voice_position[vcnt];
  assign i0         = cur_pos[FRAC_W +: ADDR_W];
  assign i0p1       = {1'b0, i0} + 17'd1;
  assign i1         = (i0p1 < len_eff) ? i0p1[ADDR_W-1:0] : i0;
  assign last_voice = (vcnt == VOICE_W'(VOICE_COUNT - 1));

  assign mem_we   = (state == S_EXEC) && (op_q == OP_LOAD);
  assign mem_addr = (state == S_EXEC) ? addr_q : ((state == S_RD1) ? i1 : i0);

  assign mod_start = (state == S_VCHK) && voice_active[vcnt] && (len_eff != '0) &&
                     (cur_pos[POS_W-1:FRAC_W] >= INT_W'(len_eff)) && loop_enable;

  svm_sample_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (value_q),
    .rdata (mem_rdata)
  );

  svm_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (cur_pos[POS_W-1:FRAC_W]),
    .divisor   (len_eff),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Datapath terms feeding and leaving the shared multiplier.
  assign diff   = {mem_rdata[SAMPLE_W-1], mem_rdata} - {s0[SAMPLE_W-1], s0};
  assign interp = {s0[SAMPLE_W-1], s0} + mul_p[32:16];
  assign scaled = mul_p[23:0];
  assign mag    = scaled[23] ? 23'(-scaled) : scaled[22:0];
  assign q_est  = mul_p[RECIP_SHIFT +: 16];
  assign rem127 = {1'b0, mag_q} - (24'({q_est, 7'b0}) - 24'(q_est));
  assign q_fix  = (rem127 >= 24'd127) ? q_est + 16'd1 : q_est;
  assign q_ext  = MIX_W'(q_fix);

  always_comb begin
    case (state)
      S_MUL1: begin
        mul_a = 24'(signed'(diff));
        mul_b = 25'(cur_pos[FRAC_W-1:0]);
      end
      S_MUL2: begin
        mul_a = 24'(signed'(interp[SAMPLE_W-1:0]));
        mul_b = 25'(voice_velocity[vcnt]);
      end
      S_MUL3: begin
        mul_a = 24'(mag);
        mul_b = RECIP_127;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    slot = '0;
    for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
      if (!voice_active[i]) begin
        slot = VOICE_W'(i);
      end
    end
  end

  always_comb begin
    if ($signed(mix) > $signed(MIX_W'(32767))) begin
      sat = 16'h7fff;
    end else if ($signed(mix) < $signed(-MIX_W'(32768))) begin
      sat = 16'h8000;
    end else begin
      sat = mix[15:0];
    end
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      sample_length <= '0;
      loop_enable   <= 1'b0;
      m_tvalid      <= 1'b0;
      vcnt          <= '0;
      for (int i = 0; i < VOICE_COUNT; i++) begin
        voice_active[i]   <= 1'b0;
        voice_note[i]     <= '0;
        voice_position[i] <= '0;
        voice_rate[i]     <= '0;
        voice_velocity[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_LENGTH) begin
          sample_length <= cfg_data;
        end else begin
          loop_enable <= cfg_data[0];
        end
      end
      // In the output state the register is reloaded instead.
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_q    <= s_tdata[1:0];
            addr_q  <= s_tdata[17:2];
            value_q <= s_tdata[33:18];
            note_q  <= s_tdata[40:34];
            vel_q   <= s_tdata[47:41];
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          if (op_q == OP_NOTE) begin
            if (vel_q == '0) begin
              for (int i = 0; i < VOICE_COUNT; i++) begin
                if (voice_active[i] && voice_note[i] == note_q) begin
                  voice_active[i] <= 1'b0;
                end
              end
            end else begin
              voice_active[slot]   <= 1'b1;
              voice_note[slot]     <= note_q;
              voice_position[slot] <= '0;
              voice_velocity[slot] <= vel_q;
              voice_rate[slot]     <= pitch_rate(note_q);
            end
          end else if (op_q == OP_TICK) begin
            vcnt  <= '0;
            mix   <= '0;
            state <= S_VCHK;
          end
        end
        S_VCHK: begin
          if (!voice_active[vcnt] || len_eff == '0) begin
            vcnt  <= vcnt + VOICE_W'(1);
            state <= last_voice ? S_OUT : S_VCHK;
          end else if (cur_pos[POS_W-1:FRAC_W] >= INT_W'(len_eff)) begin
            if (loop_enable) begin
              state <= S_VMOD;
            end else begin
              voice_active[vcnt] <= 1'b0;
              vcnt  <= vcnt + VOICE_W'(1);
              state <= last_voice ? S_OUT : S_VCHK;
            end
          end else begin
            state <= S_RD0;
          end
        end
        S_VMOD: begin
          if (mod_done) begin
            voice_position[vcnt] <= {INT_W'(mod_rem), cur_pos[FRAC_W-1:0]};
            state <= S_RD0;
          end
        end
        S_RD0: begin
          state <= S_RD1;
        end
        S_RD1: begin
          s0    <= mem_rdata;
          state <= S_MUL1;
        end
        S_MUL1: begin
          state <= S_MUL2;
        end
        S_MUL2: begin
          state <= S_MUL3;
        end
        S_MUL3: begin
          neg_q <= scaled[23];
          mag_q <= mag;
          state <= S_CORR;
        end
        S_CORR: begin
          mix <= neg_q ? mix - q_ext : mix + q_ext;
          voice_position[vcnt] <= cur_pos + POS_W'(voice_rate[vcnt]);
          vcnt  <= vcnt + VOICE_W'(1);
          state <= last_voice ? S_OUT : S_VCHK;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= sat;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/svm_sample_mem.sv
// ----------------------------------------------------------------------------
// svm_sample_mem
// Single-port sample store with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module svm_sample_mem
  import svm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [ADDR_W-1:0]   addr,
  input  wire logic [SAMPLE_W-1:0] wdata,
  output logic      [SAMPLE_W-1:0] rdata
);

  logic [SAMPLE_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// File: rtl/svm_mod_unit.sv
// ----------------------------------------------------------------------------
// svm_mod_unit
// Restoring remainder of the integer play position by the sample length,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module svm_mod_unit
  import svm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [INT_W-1:0] dividend,
  input  wire logic [LEN_W-1:0] divisor,
  output logic                  done,
  output logic      [LEN_W-1:0] remainder
);

  localparam int CNT_W = $clog2(INT_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [INT_W-1:0] num;
  logic [LEN_W-1:0] den;
  logic [LEN_W-1:0] rem;
  logic [LEN_W:0]   trial;

  assign trial     = {rem, num[INT_W-1]};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(INT_W - 1);
        num  <= dividend;
        den  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        num <= num << 1;
        if (trial >= {1'b0, den}) begin
          rem <= LEN_W'(trial - {1'b0, den});
        end else begin
          rem <= LEN_W'(trial);
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire
